// ===== rtl/core/rbs_pkg.sv =====
package rbs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_RASTER_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_RASTER_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_NODATA_VALUE  = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X      = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y      = 3'd4;
  localparam logic [2:0] CFG_SCALE_X       = 3'd5;
  localparam logic [2:0] CFG_SCALE_Y       = 3'd6;

  // input kinds carried on tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // store and serial multiplier widths fixed by the field formats
  localparam int STORE_AW  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int ELEV_W    = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RANGE,
    ST_ADDR,
    ST_READ,
    ST_CHECK,
    ST_NEARW,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [STORE_AW-1:0]   waddr;
    logic [SAMPLE_W-1:0]   wdata;
    logic [STORE_AW-1:0]   raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/rbs_serial_mul.sv =====
module rbs_serial_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [rbs_pkg::MUL_A_W-1:0]  a,
  input  logic signed [rbs_pkg::MUL_B_W-1:0]  b,
  output logic                                done,
  output logic signed [rbs_pkg::MUL_P_W-1:0]  product
);

  localparam int AW = rbs_pkg::MUL_A_W;
  localparam int BW = rbs_pkg::MUL_B_W;
  localparam int PW = rbs_pkg::MUL_P_W;
  localparam int CW = rbs_pkg::MUL_CNT_W;

  logic [AW-1:0]   mcand_r;
  logic [AW:0]     hi_r;
  logic [BW-1:0]   lo_r;
  logic            neg_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [AW-1:0]   abs_a;
  logic [BW-1:0]   abs_b;
  logic [AW+1:0]   sum;
  logic [PW-1:0]   mag;

  always_comb begin
    abs_a = a[AW-1] ? AW'(-a) : AW'(a);
    abs_b = b[BW-1] ? BW'(-b) : BW'(b);
    sum   = {1'b0, hi_r} + (lo_r[0] ? {2'b00, mcand_r} : '0);
    mag   = {hi_r, lo_r};
    product = neg_r ? $signed(-mag) : $signed(mag);
  end

  // one multiplier bit per cycle, right-shifting accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= abs_a;
      hi_r    <= '0;
      lo_r    <= abs_b;
      neg_r   <= a[AW-1] ^ b[BW-1];
    end else if (busy_r) begin
      hi_r <= sum[AW+1:1];
      lo_r <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/core/rbs_raster_mem.sv =====
module rbs_raster_mem (
  input  logic                           clk,
  input  rbs_pkg::mem_req_t              req,
  output logic [rbs_pkg::SAMPLE_W-1:0]   rdata
);

  logic [rbs_pkg::SAMPLE_W-1:0] mem [2**rbs_pkg::STORE_AW];
  logic [rbs_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/raster_bilinear_sampler_core.sv =====
// raster bilinear sampler
// holds a 65536 x 16 bit elevation raster and answers point queries
// input stream: in_tuser selects the kind, write sample or query point;
//   a write transaction stores one sample and yields no result, a query
//   transaction yields exactly one result transaction
// output stream: out_tdata carries the elevation (8 fractional bits),
//   out_tuser flags a result equal to the nodata value
// configuration: cfg_we writes register cfg_addr with cfg_wdata at once
// sequence: a write is stored as it is accepted; a query runs the bit-serial
//   coordinate multipliers (x and y run side by side) and a range check,
//   then address and corner reads through the single read port, then the
//   nearest-pixel fallback or the shared blend multiplier, and a hand-over
//   step; a query outside the raster skips from the range check to the
//   hand-over, a query before any write goes straight to it, and no input
//   is taken until the query is handed over
// reset: clears configuration to defaults and the loaded flag; the raster
//   contents are not cleared and are undefined until written
// stall: a finished result waits in the output register; the next item is
//   accepted meanwhile, and a further result waits until that register empties
module raster_bilinear_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // sample_index, sample_value, query_x, query_y
  input  logic        in_tuser,   // action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // elevation
  output logic        out_tuser   // is_nodata
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int F   = FRAC_BITS;
  localparam int VW  = rbs_pkg::SAMPLE_W + F + 2;      // one-axis blend
  localparam int PW  = VW + F + 2;                     // blend product
  localparam int SW  = PW + 1;                         // final sum
  localparam int RS  = 2 * F - 8;                      // rounding shift
  localparam logic signed [SW-1:0] RND = (RS > 0) ? SW'(1) <<< (RS - 1) : '0;
  localparam int AW  = rbs_pkg::STORE_AW;
  localparam int EW  = rbs_pkg::ELEV_W;

  // configuration registers
  logic [8:0]         raster_width_r;
  logic [8:0]         raster_height_r;
  logic signed [15:0] nodata_value_r;
  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic signed [31:0] scale_x_r;
  logic signed [31:0] scale_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_width_r  <= 9'd256;
      raster_height_r <= 9'd256;
      nodata_value_r  <= 16'sh8000;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      scale_x_r       <= 32'sd4915200;
      scale_y_r       <= -32'sd4915200;
    end else if (cfg_we) begin
      case (cfg_addr)
        rbs_pkg::CFG_RASTER_WIDTH:  raster_width_r  <= cfg_wdata[8:0];
        rbs_pkg::CFG_RASTER_HEIGHT: raster_height_r <= cfg_wdata[8:0];
        rbs_pkg::CFG_NODATA_VALUE:  nodata_value_r  <= cfg_wdata[15:0];
        rbs_pkg::CFG_ORIGIN_X:      origin_x_r      <= cfg_wdata;
        rbs_pkg::CFG_ORIGIN_Y:      origin_y_r      <= cfg_wdata;
        rbs_pkg::CFG_SCALE_X:       scale_x_r       <= cfg_wdata;
        rbs_pkg::CFG_SCALE_Y:       scale_y_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack input transaction
  logic [15:0]        in_sample_index;
  logic [15:0]        in_sample_value;
  logic signed [31:0] in_query_x;
  logic signed [31:0] in_query_y;
  assign in_sample_index = in_tdata[15:0];
  assign in_sample_value = in_tdata[31:16];
  assign in_query_x      = in_tdata[63:32];
  assign in_query_y      = in_tdata[95:64];

  // size registers saturated to the supported range
  logic [WDW-1:0] w_cl;
  logic [HDW-1:0] h_cl;
  always_comb begin
    if (raster_width_r < 9'd2) begin
      w_cl = WDW'(2);
    end else if (32'(raster_width_r) > MAX_WIDTH) begin
      w_cl = WDW'(MAX_WIDTH);
    end else begin
      w_cl = WDW'(raster_width_r);
    end
    if (raster_height_r < 9'd2) begin
      h_cl = HDW'(2);
    end else if (32'(raster_height_r) > MAX_HEIGHT) begin
      h_cl = HDW'(MAX_HEIGHT);
    end else begin
      h_cl = HDW'(raster_height_r);
    end
  end

  rbs_pkg::state_t state_r, state_nxt;
  logic in_acc;
  logic out_free;
  logic loaded_r;

  assign in_tready = (state_r == rbs_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // coordinate multipliers, one per axis
  logic                                mul_start;
  logic signed [rbs_pkg::MUL_A_W-1:0]  dx, dy;
  logic                                mul_x_done, mul_y_done;
  logic signed [rbs_pkg::MUL_P_W-1:0]  px, py;

  assign mul_start = in_acc && (in_tuser == rbs_pkg::ACT_QUERY) && loaded_r;
  assign dx = {in_query_x[31], in_query_x} - {origin_x_r[31], origin_x_r};
  assign dy = {in_query_y[31], in_query_y} - {origin_y_r[31], origin_y_r};

  rbs_serial_mul u_mul_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (dx),
    .b       (scale_x_r),
    .done    (mul_x_done),
    .product (px)
  );

  rbs_serial_mul u_mul_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (dy),
    .b       (scale_y_r),
    .done    (mul_y_done),
    .product (py)
  );

  // raster store
  rbs_pkg::mem_req_t mem_req;
  logic [15:0]       mem_rdata;

  rbs_raster_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // query datapath registers
  logic signed [rbs_pkg::MUL_P_W-1:0] px_r, py_r;
  logic [XW-1:0]      x0_r;
  logic [YW-1:0]      y0_r;
  logic [F-1:0]       fx_r, fy_r;
  logic [AW-1:0]      base_r;
  logic [2:0]         cnt_r;
  logic signed [15:0] corner_r [4];
  logic signed [VW-1:0] v0_r, v1_r;
  logic signed [PW-1:0] acc_r, prod_r;
  logic signed [EW-1:0] elev_r;
  logic                 out_valid_r;
  logic [EW-1:0]        out_elev_r;
  logic                 out_nod_r;

  // range test on the q.32 pixel coordinates
  logic out_of_range;
  always_comb begin
    out_of_range = px_r[rbs_pkg::MUL_P_W-1] || py_r[rbs_pkg::MUL_P_W-1] ||
      (px_r[rbs_pkg::MUL_P_W-1:32] >= (rbs_pkg::MUL_P_W-32)'(w_cl - 1'b1)) ||
      (py_r[rbs_pkg::MUL_P_W-1:32] >= (rbs_pkg::MUL_P_W-32)'(h_cl - 1'b1));
  end

  // corner and nearest-pixel addresses
  logic [AW-1:0] corner_addr;
  logic [AW-1:0] near_addr;
  logic [AW-1:0] w_addr;
  logic          any_nod;
  assign w_addr = AW'(w_cl);
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    corner_addr = base_r;
      2'd1:    corner_addr = base_r + 1'b1;
      2'd2:    corner_addr = base_r + w_addr;
      default: corner_addr = base_r + w_addr + 1'b1;
    endcase
    near_addr = base_r + AW'(fx_r[F-1]) + (fy_r[F-1] ? w_addr : '0);
    any_nod = (corner_r[0] == nodata_value_r) || (corner_r[1] == nodata_value_r) ||
              (corner_r[2] == nodata_value_r) || (corner_r[3] == nodata_value_r);
  end

  // shared blend multiplier, operands chosen by step
  logic signed [VW-1:0] bm_a;
  logic [F:0]           bm_b;
  logic [F:0]           one_fx, one_fy;
  logic signed [PW-1:0] bm_p;
  logic signed [SW-1:0] fsum;
  assign one_fx = (F+1)'(1 << F) - (F+1)'(fx_r);
  assign one_fy = (F+1)'(1 << F) - (F+1)'(fy_r);
  always_comb begin
    case (cnt_r)
      3'd0:    begin bm_a = VW'(corner_r[0]); bm_b = one_fx; end
      3'd1:    begin bm_a = VW'(corner_r[1]); bm_b = {1'b0, fx_r}; end
      3'd2:    begin bm_a = VW'(corner_r[2]); bm_b = one_fx; end
      3'd3:    begin bm_a = VW'(corner_r[3]); bm_b = {1'b0, fx_r}; end
      3'd4:    begin bm_a = v0_r; bm_b = one_fy; end
      default: begin bm_a = v1_r; bm_b = {1'b0, fy_r}; end
    endcase
    bm_p = PW'(bm_a) * PW'($signed({1'b0, bm_b}));
    fsum = SW'(acc_r) + SW'(prod_r) + RND;
  end

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    mem_req.we    = in_acc && (in_tuser == rbs_pkg::ACT_WRITE);
    mem_req.waddr = in_sample_index;
    mem_req.wdata = in_sample_value;
    mem_req.raddr = corner_addr;
    case (state_r)
      rbs_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == rbs_pkg::ACT_QUERY)) begin
          state_nxt = loaded_r ? rbs_pkg::ST_MUL : rbs_pkg::ST_DONE;
        end
      end
      rbs_pkg::ST_MUL:   if (mul_x_done && mul_y_done) state_nxt = rbs_pkg::ST_RANGE;
      rbs_pkg::ST_RANGE: state_nxt = out_of_range ? rbs_pkg::ST_DONE : rbs_pkg::ST_ADDR;
      rbs_pkg::ST_ADDR:  state_nxt = rbs_pkg::ST_READ;
      rbs_pkg::ST_READ:  if (cnt_r == 3'd4) state_nxt = rbs_pkg::ST_CHECK;
      rbs_pkg::ST_CHECK: begin
        mem_req.raddr = near_addr;
        state_nxt = any_nod ? rbs_pkg::ST_NEARW : rbs_pkg::ST_BLEND;
      end
      rbs_pkg::ST_NEARW: state_nxt = rbs_pkg::ST_DONE;
      rbs_pkg::ST_BLEND: if (cnt_r == 3'd6) state_nxt = rbs_pkg::ST_DONE;
      rbs_pkg::ST_DONE:  if (out_free) state_nxt = rbs_pkg::ST_IDLE;
      default:           state_nxt = rbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbs_pkg::ST_IDLE;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_req.we) begin
        loaded_r <= 1'b1;
      end
      if (state_r == rbs_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else if (state_r == rbs_pkg::ST_READ || state_r == rbs_pkg::ST_BLEND) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      rbs_pkg::ST_IDLE: elev_r <= '0;
      rbs_pkg::ST_MUL: begin
        if (mul_x_done) begin
          px_r <= px;
          py_r <= py;
        end
      end
      rbs_pkg::ST_RANGE: begin
        elev_r <= {nodata_value_r, 8'h00};
        x0_r   <= px_r[32+XW-1:32];
        y0_r   <= py_r[32+YW-1:32];
        fx_r   <= px_r[31:32-F];
        fy_r   <= py_r[31:32-F];
      end
      rbs_pkg::ST_ADDR: base_r <= AW'(32'(y0_r) * 32'(w_cl) + 32'(x0_r));
      rbs_pkg::ST_READ: begin
        if (cnt_r != 3'd0) begin
          corner_r[cnt_r[1:0] - 2'd1] <= mem_rdata;
        end
      end
      rbs_pkg::ST_NEARW: elev_r <= {mem_rdata, 8'h00};
      rbs_pkg::ST_BLEND: begin
        prod_r <= bm_p;
        case (cnt_r)
          3'd1, 3'd3, 3'd5: acc_r <= prod_r;
          3'd2: v0_r <= VW'(acc_r + prod_r);
          3'd4: v1_r <= VW'(acc_r + prod_r);
          3'd6: elev_r <= EW'(fsum >>> RS);
          default: ;
        endcase
      end
      rbs_pkg::ST_DONE: begin
        if (out_free) begin
          out_elev_r <= elev_r;
          out_nod_r  <= (elev_r == {nodata_value_r, 8'h00});
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elev_r;
  assign out_tuser  = out_nod_r;

endmodule

// ===== rtl/core/rbs_checker.sv =====
module rbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a write transaction never raises a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == rbs_pkg::ACT_WRITE) |=> !$rose(out_tvalid))
    else $error("result after a write");

  // a query is worked on alone
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == rbs_pkg::ACT_QUERY) |=> !in_tready)
    else $error("input taken during a query");

  // an accepted item raises no result in the cycle after it
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

endmodule

bind raster_bilinear_sampler_core rbs_checker u_rbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
